FILE: rtl/core/assert_macros.svh
// Assertion helpers, included by sha_ctrl.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPL(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");
`define ASSERT_NEVER(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("forbidden condition");
`else
`define ASSERT_IMPL(label, clk, rst_n, prop)
`define ASSERT_NEVER(label, clk, rst_n, cond)
`endif
`endif

FILE: rtl/core/sha_pkg.sv
package sha_pkg;

    localparam int BlockBytes = 64;
    localparam int Rounds     = 64;
    localparam int PadStart   = 56;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       has_byte;
        logic       last;
    } sha_in_t;

    typedef struct packed {
        logic [31:0] digest_word;
        logic [2:0]  word_index;
        logic        last_word;
    } sha_out_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ROUND,
        ST_ADD,
        ST_PAD,
        ST_EMIT
    } sha_state_t;

    // Byte source written into the block buffer.
    typedef enum logic [1:0] {
        SRC_DATA,
        SRC_MARK,
        SRC_ZERO,
        SRC_LEN
    } sha_src_t;

    // Commands from controller to datapath.
    typedef struct packed {
        logic     buf_wr;
        sha_src_t src;
        logic     round_init;
        logic     round_step;
        logic     hash_add;
        logic     msg_done;
    } sha_cmd_t;

    // Status from datapath to controller.
    typedef struct packed {
        logic [5:0] fill;
        logic [5:0] round;
    } sha_stat_t;

    localparam logic [31:0] InitHash [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [31:0] RoundK [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    function automatic logic [31:0] rotr(input logic [31:0] x, input int s);
        rotr = (x >> s) | (x << (32 - s));
    endfunction

endpackage

FILE: rtl/core/sha_ctrl.sv
module sha_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  sha_pkg::sha_in_t  in_item,
    output logic              in_ready,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [2:0]        out_index,
    input  sha_pkg::sha_stat_t stat,
    output sha_pkg::sha_cmd_t cmd
);
    import sha_pkg::*;

    sha_state_t state_reg, state_next;
    logic       fin_reg, fin_next;     // message must be finished after block
    logic       lenblk_reg, lenblk_next; // current padded block holds length
    logic       padblk_reg, padblk_next; // running a padding block
    logic [2:0] emit_reg, emit_next;

    logic in_fire;
    assign in_fire  = in_valid && in_ready;
    assign in_ready = (state_reg == ST_IDLE);
    assign out_valid = (state_reg == ST_EMIT);
    assign out_index = emit_reg;

    // Next state.
    always_comb
    begin
        state_next  = state_reg;
        fin_next    = fin_reg;
        lenblk_next = lenblk_reg;
        padblk_next = padblk_reg;
        emit_next   = emit_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    fin_next    = in_item.last;
                    padblk_next = 1'b0;
                    if (in_item.has_byte && stat.fill == 6'd63)
                        state_next = ST_ROUND;
                    else if (in_item.last)
                    begin
                        state_next  = ST_PAD;
                        lenblk_next = (in_item.has_byte ? stat.fill + 6'd1 : stat.fill)
                                      < 6'(PadStart);
                    end
                end
            end
            ST_ROUND:
            begin
                if (stat.round == 6'(Rounds - 1))
                    state_next = ST_ADD;
            end
            ST_ADD:
            begin
                if (padblk_reg && lenblk_reg)
                begin
                    state_next = ST_EMIT;
                    emit_next  = 3'd0;
                end
                else if (fin_reg)
                begin
                    // Byte completed a block, or first of two pad blocks.
                    state_next  = ST_PAD;
                    lenblk_next = 1'b1;
                    padblk_next = 1'b0;
                end
                else
                    state_next = ST_IDLE;
            end
            ST_PAD:
            begin
                if (stat.fill == 6'(BlockBytes - 1))
                begin
                    state_next  = ST_ROUND;
                    padblk_next = 1'b1;
                end
            end
            ST_EMIT:
            begin
                if (out_ready)
                begin
                    emit_next = emit_reg + 3'd1;
                    if (emit_reg == 3'd7)
                        state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Pad source tracking: mark written once per message at the fill point.
    logic mark_done_reg, mark_done_next;

    // Outputs.
    always_comb
    begin
        cmd = '0;
        cmd.src = SRC_DATA;
        mark_done_next = mark_done_reg;
        case (state_reg)
            ST_IDLE:
            begin
                mark_done_next = 1'b0;
                if (in_fire && in_item.has_byte)
                begin
                    cmd.buf_wr = 1'b1;
                    cmd.src    = SRC_DATA;
                end
                if (in_fire && in_item.has_byte && stat.fill == 6'd63)
                    cmd.round_init = 1'b1;
            end
            ST_ROUND:
                cmd.round_step = 1'b1;
            ST_ADD:
                cmd.hash_add = 1'b1;
            ST_PAD:
            begin
                cmd.buf_wr = 1'b1;
                if (!mark_done_reg)
                begin
                    cmd.src = SRC_MARK;
                    mark_done_next = 1'b1;
                end
                else if (lenblk_reg && stat.fill >= 6'(PadStart))
                    cmd.src = SRC_LEN;
                else
                    cmd.src = SRC_ZERO;
                if (stat.fill == 6'(BlockBytes - 1))
                    cmd.round_init = 1'b1;
            end
            ST_EMIT:
            begin
                // The eighth word leaving ends the message.
                if (out_ready && emit_reg == 3'd7)
                    cmd.msg_done = 1'b1;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            fin_reg       <= 1'b0;
            lenblk_reg    <= 1'b0;
            padblk_reg    <= 1'b0;
            emit_reg      <= 3'd0;
            mark_done_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            fin_reg       <= fin_next;
            lenblk_reg    <= lenblk_next;
            padblk_reg    <= padblk_next;
            emit_reg      <= emit_next;
            mark_done_reg <= mark_done_next;
        end
    end

`include "assert_macros.svh"
    `ASSERT_IMPL(a_emit_from_add, clk, rst_n,
        ($rose(state_reg == ST_EMIT) |-> $past(state_reg) == ST_ADD))
    `ASSERT_IMPL(a_emit_hold, clk, rst_n,
        (out_valid && !out_ready |=> out_valid && $stable(emit_reg)))
    `ASSERT_NEVER(a_no_accept_busy, clk, rst_n, in_ready && out_valid)
endmodule

FILE: rtl/core/sha_dp.sv
module sha_dp (
    input  logic               clk,
    input  logic               rst_n,
    input  sha_pkg::sha_cmd_t  cmd,
    input  logic [7:0]         data_byte,
    input  logic [2:0]         out_index,
    output logic [31:0]        digest_word,
    output sha_pkg::sha_stat_t stat
);
    import sha_pkg::*;

    logic [5:0]  fill_reg;
    logic [5:0]  round_reg;
    logic [63:0] bits_reg;
    logic [31:0] hash_reg [8];
    logic [31:0] v_reg [8];
    logic [31:0] w_reg [16];

    logic [7:0]  wr_byte;
    logic [31:0] w_cur, w_new, s0, s1, t1, t2, ch, mj, e, a;
    logic [31:0] hash_sum [8];

    assign stat.fill  = fill_reg;
    assign stat.round = round_reg;

    // Byte written into the block buffer; the length goes out most
    // significant byte first in the last eight slots.
    always_comb
    begin
        case (cmd.src)
            SRC_DATA: wr_byte = data_byte;
            SRC_MARK: wr_byte = 8'h80;
            SRC_ZERO: wr_byte = 8'h00;
            SRC_LEN:  wr_byte = bits_reg[{3'd7 - fill_reg[2:0], 3'b000} +: 8];
            default:  wr_byte = 8'h00;
        endcase
    end

    // Message schedule and round function.
    always_comb
    begin
        s0    = rotr(w_reg[1], 7) ^ rotr(w_reg[1], 18) ^ (w_reg[1] >> 3);
        s1    = rotr(w_reg[14], 17) ^ rotr(w_reg[14], 19) ^ (w_reg[14] >> 10);
        w_new = w_reg[0] + s0 + w_reg[9] + s1;
        w_cur = w_reg[0];
        a  = v_reg[0];
        e  = v_reg[4];
        ch = (e & v_reg[5]) ^ (~e & v_reg[6]);
        mj = (a & v_reg[1]) ^ (a & v_reg[2]) ^ (v_reg[1] & v_reg[2]);
        t1 = v_reg[7] + (rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25)) + ch
             + RoundK[round_reg] + w_cur;
        t2 = (rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22)) + mj;
        for (int i = 0; i < 8; i++)
            hash_sum[i] = hash_reg[i] + v_reg[i];
    end

    assign digest_word = hash_reg[out_index];

    // Message window: bytes land big-endian in place as the block fills,
    // then the window slides by one word per round.
    always_ff @(posedge clk)
    begin
        if (cmd.round_step)
        begin
            for (int i = 0; i < 15; i++)
                w_reg[i] <= w_reg[i + 1];
            w_reg[15] <= w_new;
        end
        else if (cmd.buf_wr)
            w_reg[fill_reg[5:2]][{2'd3 - fill_reg[1:0], 3'b000} +: 8] <= wr_byte;
    end

    // Working variables, loaded from the hash state when a block starts.
    always_ff @(posedge clk)
    begin
        if (cmd.round_init)
        begin
            for (int i = 0; i < 8; i++)
                v_reg[i] <= hash_reg[i];
        end
        else if (cmd.round_step)
        begin
            v_reg[7] <= v_reg[6];
            v_reg[6] <= v_reg[5];
            v_reg[5] <= v_reg[4];
            v_reg[4] <= v_reg[3] + t1;
            v_reg[3] <= v_reg[2];
            v_reg[2] <= v_reg[1];
            v_reg[1] <= v_reg[0];
            v_reg[0] <= t1 + t2;
        end
    end

    // Control-bearing state. The bit count grows by eight per message byte
    // and wraps at 64 bits; the fill count wraps to zero at the block end.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg  <= '0;
            round_reg <= '0;
            bits_reg  <= '0;
            for (int i = 0; i < 8; i++)
                hash_reg[i] <= InitHash[i];
        end
        else
        begin
            if (cmd.buf_wr)
                fill_reg <= fill_reg + 6'd1;
            if (cmd.round_init)
                round_reg <= '0;
            else if (cmd.round_step)
                round_reg <= round_reg + 6'd1;
            if (cmd.hash_add)
            begin
                for (int i = 0; i < 8; i++)
                    hash_reg[i] <= hash_sum[i];
            end
            else if (cmd.msg_done)
            begin
                // Reload the initial value once the digest has been shown.
                for (int i = 0; i < 8; i++)
                    hash_reg[i] <= InitHash[i];
            end
            if (cmd.msg_done)
                bits_reg <= '0;
            else if (cmd.buf_wr && cmd.src == SRC_DATA)
                bits_reg <= bits_reg + 64'd8;
        end
    end
endmodule

FILE: rtl/core/sha256_byte_stream_hasher_core.sv
// SHA-256 byte stream hasher.
// Input channel (in_valid/in_ready, in_data): one byte per transaction, with
// has_byte marking a real byte and last ending the message. A transaction
// with last and no byte finishes the message as it stands.
// Output channel (out_valid/out_ready, out_data): eight digest words per
// message, word 0 (most significant) first, last_word set on word 7.
// The 64th byte of a block starts the rounds and the hash add, run by the
// single shared round unit. Finishing writes the remaining pad bytes one per
// cycle and runs one or two blocks, the second when the length does not fit.
// Input is held off while padding, while a block runs and while words are shown.
// A stalled receiver simply holds the current word; nothing is lost.
// After the eighth word the initial hash value is reloaded and the bit count
// cleared. Reset loads the initial hash value and empties the buffer.
module sha256_byte_stream_hasher_core (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  sha_pkg::sha_in_t  in_data,
    output logic              out_valid,
    input  logic              out_ready,
    output sha_pkg::sha_out_t out_data
);
    import sha_pkg::*;

    sha_cmd_t   cmd;
    sha_stat_t  stat;
    logic [2:0] out_index;
    logic [31:0] word;

    sha_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_item(in_data),
        .in_ready(in_ready), .out_valid(out_valid), .out_ready(out_ready),
        .out_index(out_index), .stat(stat), .cmd(cmd)
    );

    sha_dp u_dp (
        .clk(clk), .rst_n(rst_n), .cmd(cmd), .data_byte(in_data.data_byte),
        .out_index(out_index), .digest_word(word), .stat(stat)
    );

    assign out_data.digest_word = word;
    assign out_data.word_index  = out_index;
    assign out_data.last_word   = (out_index == 3'd7);
endmodule

FILE: test/tb_sha256_byte_stream_hasher_core.sv
module tb_sha256_byte_stream_hasher_core;
    import sha_pkg::*;

    localparam logic [31:0] HashInit [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [31:0] KTable [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    localparam int CycleLimit = 400000;

    logic     clk;
    logic     rst_n;
    logic     in_valid;
    logic     in_ready;
    sha_in_t  in_data;
    logic     out_valid;
    logic     out_ready;
    sha_out_t out_data;

    sha256_byte_stream_hasher_core dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_data  (in_data),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .out_data (out_data)
    );

    // Predictor state for the running message.
    logic [31:0] hash_state [8];
    logic [7:0]  blk_bytes [64];
    int          blk_fill;
    logic [63:0] bits_done;

    sha_in_t  byte_queue [$];
    sha_out_t digest_queue [$];
    bit       failed;
    bit       stim_done;
    bit       hold_sender;
    bit       in_accepted;
    int       hold_receiver;
    int       cycle_count;

    function automatic logic [31:0] ror32(input logic [31:0] x, input int s);
        return (x >> s) | (x << (32 - s));
    endfunction

    // One compression of the buffered block into the hash state.
    task automatic compress_block();
        logic [31:0] w [64];
        logic [31:0] v [8];
        logic [31:0] t1;
        logic [31:0] t2;
        for (int r = 0; r < 16; r++)
            w[r] = {blk_bytes[4*r], blk_bytes[4*r+1], blk_bytes[4*r+2], blk_bytes[4*r+3]};
        for (int r = 16; r < 64; r++)
            w[r] = w[r-16] + w[r-7]
                 + (ror32(w[r-15], 7) ^ ror32(w[r-15], 18) ^ (w[r-15] >> 3))
                 + (ror32(w[r-2], 17) ^ ror32(w[r-2], 19) ^ (w[r-2] >> 10));
        for (int i = 0; i < 8; i++)
            v[i] = hash_state[i];
        for (int r = 0; r < 64; r++)
        begin
            t1 = v[7] + (ror32(v[4], 6) ^ ror32(v[4], 11) ^ ror32(v[4], 25))
               + ((v[4] & v[5]) ^ (~v[4] & v[6])) + KTable[r] + w[r];
            t2 = (ror32(v[0], 2) ^ ror32(v[0], 13) ^ ror32(v[0], 22))
               + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
            v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
            v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
        end
        for (int i = 0; i < 8; i++)
            hash_state[i] += v[i];
    endtask

    task automatic reset_digest_state();
        for (int i = 0; i < 8; i++)
            hash_state[i] = HashInit[i];
        blk_fill = 0;
        bits_done = '0;
    endtask

    // Predict the digest words caused by one accepted transaction.
    task automatic predict_digest(input sha_in_t item);
        int          pos;
        logic [63:0] total;
        sha_out_t    word;
        if (item.has_byte)
        begin
            blk_bytes[blk_fill] = item.data_byte;
            blk_fill++;
            if (blk_fill == 64)
            begin
                compress_block();
                bits_done += 64'd512;
                blk_fill = 0;
            end
        end
        if (item.last)
        begin
            // Padding: marker byte, zeros, then the 64-bit length.
            pos = blk_fill;
            total = bits_done + 64'(pos * 8);
            blk_bytes[pos] = 8'h80;
            pos++;
            if (pos > 56)
            begin
                while (pos < 64)
                    blk_bytes[pos++] = 8'h00;
                compress_block();
                pos = 0;
            end
            while (pos < 56)
                blk_bytes[pos++] = 8'h00;
            for (int b = 0; b < 8; b++)
                blk_bytes[56+b] = total[63-8*b -: 8];
            compress_block();
            for (int j = 0; j < 8; j++)
            begin
                word.digest_word = hash_state[j];
                word.word_index = 3'(j);
                word.last_word = (j == 7);
                digest_queue.push_back(word);
            end
            reset_digest_state();
        end
    endtask

    task automatic add_message(input int len, input bit end_with_byte);
        sha_in_t item;
        for (int i = 0; i < len; i++)
        begin
            item.data_byte = 8'($urandom_range(0, 255));
            item.has_byte = 1'b1;
            item.last = end_with_byte && (i == len - 1);
            byte_queue.push_back(item);
            // Occasional empty transaction that the block ignores.
            if ($urandom_range(0, 19) == 0)
            begin
                item.has_byte = 1'b0;
                item.last = 1'b0;
                byte_queue.push_back(item);
            end
        end
        if (!end_with_byte || len == 0)
        begin
            item.data_byte = 8'($urandom_range(0, 255));
            item.has_byte = 1'b0;
            item.last = 1'b1;
            byte_queue.push_back(item);
        end
    endtask

    task automatic wait_drained();
        while (byte_queue.size() != 0 || in_valid || digest_queue.size() != 0)
            @(posedge clk);
    endtask

    // Clock generation.
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Stimulus: directed messages first, then random ones.
    initial
    begin
        sha_in_t item;
        int      len;
        stim_done = 1'b0;
        hold_sender = 1'b0;
        hold_receiver = 0;
        reset_digest_state();
        rst_n = 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        // Empty message, then one-byte messages with byte extremes and a short one.
        add_message(0, 1'b0);
        item = '{data_byte: 8'hff, has_byte: 1'b1, last: 1'b1};
        byte_queue.push_back(item);
        item = '{data_byte: 8'h00, has_byte: 1'b1, last: 1'b1};
        byte_queue.push_back(item);
        item = '{data_byte: 8'h00, has_byte: 1'b0, last: 1'b0};
        byte_queue.push_back(item);
        add_message(3, 1'b0);
        wait_drained();
        // Long receiver hold-off while the sender keeps offering bytes.
        hold_receiver = 400;
        add_message(55, 1'b1);
        add_message(56, 1'b0);
        add_message(64, 1'b1);
        wait_drained();
        add_message(63, 1'b0);
        // Random part: short messages.
        for (int m = 0; m < 16; m++)
        begin
            len = $urandom_range(0, 12);
            add_message(len, $urandom_range(0, 1));
        end
        wait_drained();
        stim_done = 1'b1;
    end

    // Driver: presents queued transactions, changing inputs on the falling edge.
    int send_gap;
    always @(negedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            in_data <= '0;
            send_gap <= 0;
        end
        else if (!in_valid || in_accepted)
        begin
            // The front of the queue is the next transaction not yet taken.
            if (send_gap > 0)
            begin
                in_valid <= 1'b0;
                send_gap <= send_gap - 1;
            end
            else if (byte_queue.size() > 0 && !hold_sender)
            begin
                in_valid <= 1'b1;
                in_data <= byte_queue[0];
                if ($urandom_range(0, 2) == 0)
                    send_gap <= ($urandom_range(0, 15) == 0) ? $urandom_range(10, 40)
                                                             : $urandom_range(1, 3);
            end
            else
                in_valid <= 1'b0;
        end
    end

    // Predict on each accepted input transaction and retire it from the queue.
    always @(posedge clk)
    begin
        in_accepted = 1'b0;
        if (rst_n && in_valid && in_ready)
        begin
            predict_digest(in_data);
            void'(byte_queue.pop_front());
            in_accepted = 1'b1;
        end
    end

    // Receiver back-pressure, with a long hold-off when requested.
    int stall_left;
    always @(negedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            stall_left <= 0;
        end
        else if (hold_receiver > 0)
        begin
            out_ready <= 1'b0;
            hold_receiver <= hold_receiver - 1;
        end
        else if (stall_left > 0)
        begin
            out_ready <= 1'b0;
            stall_left <= stall_left - 1;
        end
        else
        begin
            out_ready <= 1'b1;
            if ($urandom_range(0, 3) == 0)
                stall_left <= ($urandom_range(0, 15) == 0) ? $urandom_range(10, 40)
                                                           : $urandom_range(1, 3);
        end
    end

    // Monitor: compare each accepted digest word with the oldest expectation.
    always @(posedge clk)
    begin
        sha_out_t exp_word;
        if (rst_n && out_valid && out_ready)
        begin
            if (digest_queue.size() == 0)
            begin
                $display("%0t: unexpected digest word %h", $time, out_data);
                failed = 1'b1;
            end
            else
            begin
                exp_word = digest_queue.pop_front();
                if (out_data.digest_word !== exp_word.digest_word
                    || out_data.word_index !== exp_word.word_index
                    || out_data.last_word !== exp_word.last_word)
                begin
                    $display("%0t: mismatch expected word %h idx %0d last %0d, got %h idx %0d last %0d",
                             $time, exp_word.digest_word, exp_word.word_index,
                             exp_word.last_word, out_data.digest_word,
                             out_data.word_index, out_data.last_word);
                    failed = 1'b1;
                end
            end
        end
    end

    // End of run and timeout.
    initial
    begin
        failed = 1'b0;
        cycle_count = 0;
        while (!stim_done && cycle_count < CycleLimit)
        begin
            @(posedge clk);
            cycle_count++;
        end
        if (stim_done)
        begin
            repeat (200) @(posedge clk);
            if (!failed && digest_queue.size() == 0)
                $display("Simulation PASSED");
            else
                $display("Simulation FAILED");
        end
        else
        begin
            $display("Simulation FAILED");
        end
        $finish;
    end
endmodule

FILE: sha256_byte_stream_hasher_core.f
+incdir+rtl/core
rtl/core/sha_pkg.sv
rtl/core/sha_ctrl.sv
rtl/core/sha_dp.sv
rtl/core/sha256_byte_stream_hasher_core.sv
test/tb_sha256_byte_stream_hasher_core.sv
